// ===== sv/fvd_pkg.sv =====
// Shared types, image layout constants and boot/label ROM tables of the FAT16 image reader.
`default_nettype none

package fvd_pkg;

    localparam int unsigned ADDR_W   = 23;
    localparam int unsigned NAME_LEN = 11;

    localparam logic [ADDR_W-1:0] FAT1_BASE = 23'd512;
    localparam logic [ADDR_W-1:0] FAT2_BASE = 23'd33280;
    localparam logic [ADDR_W-1:0] ROOT_BASE = 23'd66048;
    localparam logic [ADDR_W-1:0] DATA_BASE = 23'd82432;

    localparam logic [15:0] SIZE_CAP    = 16'h8000;
    localparam logic [15:0] FAT_MEDIA   = 16'hFFF8;
    localparam logic [15:0] FAT_RSVD    = 16'hFFFF;
    localparam logic [15:0] FAT_EOC     = 16'hFFF8;
    localparam logic [15:0] FAT_BAD     = 16'hFFF7;
    localparam logic [7:0]  BOOT_SIG_LO = 8'h55;
    localparam logic [7:0]  BOOT_SIG_HI = 8'hAA;
    localparam logic [7:0]  BOOT_FILL   = 8'h90;
    localparam logic [7:0]  ATTR_RO     = 8'h01;
    localparam logic [8:0]  BOOT_ROM_LEN = 9'd62;
    localparam logic [8:0]  BOOT_SIG_POS = 9'd510;

    // record byte offsets of a load item
    localparam logic [4:0] LD_ATTR    = 5'd11;
    localparam logic [4:0] LD_TIME_LO = 5'd12;
    localparam logic [4:0] LD_TIME_HI = 5'd13;
    localparam logic [4:0] LD_DATE_LO = 5'd14;
    localparam logic [4:0] LD_DATE_HI = 5'd15;
    localparam logic [4:0] LD_SIZE_LO = 5'd16;
    localparam logic [4:0] LD_SIZE_HI = 5'd17;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        RGN_BOOT,
        RGN_FAT,
        RGN_ROOT,
        RGN_DATA
    } region_t;

    typedef struct packed {
        region_t     region;
        logic        aux;
        logic [14:0] off;
        logic [8:0]  fi;
        logic        last;
    } s1_info_t;

    typedef struct packed {
        logic       we;
        logic [3:0] slot;
        logic [4:0] off;
        logic [7:0] value;
    } load_t;

    typedef struct packed {
        logic        writable;
        logic [15:0] size;
        logic [15:0] date;
        logic [15:0] tm;
    } meta_t;

    function automatic logic [7:0] boot_rom_byte(input logic [5:0] i);
        logic [7:0] b;
        case (i)
            6'd0:  b = 8'hEB;
            6'd1:  b = 8'h3E;
            6'd2:  b = 8'h90;
            6'd3:  b = 8'h4D;
            6'd4:  b = 8'h53;
            6'd5:  b = 8'h44;
            6'd6:  b = 8'h4F;
            6'd7:  b = 8'h53;
            6'd8:  b = 8'h35;
            6'd9:  b = 8'h2E;
            6'd10: b = 8'h30;
            6'd11: b = 8'h00;
            6'd12: b = 8'h02;
            6'd13: b = 8'h01;
            6'd14: b = 8'h01;
            6'd15: b = 8'h00;
            6'd16: b = 8'h02;
            6'd17: b = 8'h00;
            6'd18: b = 8'h02;
            6'd19: b = 8'h00;
            6'd20: b = 8'h00;
            6'd21: b = 8'hF8;
            6'd22: b = 8'h40;
            6'd23: b = 8'h00;
            6'd24: b = 8'h20;
            6'd25: b = 8'h00;
            6'd26: b = 8'h01;
            6'd27: b = 8'h00;
            6'd33: b = 8'h40;
            6'd36: b = 8'h80;
            6'd38: b = 8'h29;
            6'd43: b = 8'h43;
            6'd44: b = 8'h48;
            6'd45: b = 8'h35;
            6'd46: b = 8'h35;
            6'd47: b = 8'h58;
            6'd48: b = 8'h20;
            6'd49: b = 8'h4D;
            6'd50: b = 8'h53;
            6'd51: b = 8'h44;
            6'd52: b = 8'h20;
            6'd53: b = 8'h20;
            6'd54: b = 8'h46;
            6'd55: b = 8'h41;
            6'd56: b = 8'h54;
            6'd57: b = 8'h31;
            6'd58: b = 8'h36;
            6'd59: b = 8'h20;
            6'd60: b = 8'h20;
            6'd61: b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] label_rom_byte(input logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:  b = 8'h43;
            5'd1:  b = 8'h48;
            5'd2:  b = 8'h35;
            5'd3:  b = 8'h35;
            5'd4:  b = 8'h58;
            5'd5:  b = 8'h20;
            5'd6:  b = 8'h4D;
            5'd7:  b = 8'h53;
            5'd8:  b = 8'h44;
            5'd9:  b = 8'h20;
            5'd10: b = 8'h20;
            5'd11: b = 8'h08;
            5'd14: b = 8'h5C;
            5'd15: b = 8'h64;
            5'd16: b = 8'h22;
            5'd17: b = 8'h52;
            5'd18: b = 8'h22;
            5'd19: b = 8'h52;
            5'd22: b = 8'h5C;
            5'd23: b = 8'h64;
            5'd24: b = 8'h22;
            5'd25: b = 8'h52;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fvd_ifs.sv =====
// Valid/ready channel interfaces for requests and image bytes.
`default_nettype none

interface fvd_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [22:0] start_address;
    logic [3:0]  load_slot;
    logic [4:0]  load_byte_offset;
    logic [7:0]  load_value;

    modport source (output valid, req_type, start_address, load_slot, load_byte_offset,
                    load_value, input ready);
    modport sink (input valid, req_type, start_address, load_slot, load_byte_offset,
                  load_value, output ready);
endinterface

interface fvd_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        file_byte_flag;
    logic [3:0]  file_slot;
    logic [14:0] file_offset;

    modport source (output valid, data_byte, last_byte, file_byte_flag, file_slot,
                    file_offset, input ready);
    modport sink (input valid, data_byte, last_byte, file_byte_flag, file_slot,
                  file_offset, output ready);
endinterface

`default_nettype wire

// ===== sv/fvd_file_table.sv =====
// File table memories: name bytes and per-slot metadata, one write and one read port each.
`default_nettype none

module fvd_file_table
    import fvd_pkg::*;
#(
    parameter int unsigned MAX_FILES = 16
)
(
    input  wire logic  clk,
    input  wire load_t load,
    input  wire logic  rd_en,
    input  wire logic [((MAX_FILES > 1) ? $clog2(MAX_FILES) : 1)-1:0] meta_raddr,
    input  wire logic [$clog2(NAME_LEN * MAX_FILES)-1:0]             name_raddr,
    output meta_t      meta_rd,
    output logic [7:0] name_rd
);

    localparam int unsigned SW         = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int unsigned NAME_DEPTH = NAME_LEN * MAX_FILES;
    localparam int unsigned NAME_AW    = $clog2(NAME_DEPTH);

    logic [7:0] name_mem [NAME_DEPTH];
    meta_t      meta_mem [MAX_FILES];

    logic               slot_ok;
    logic               name_we;
    logic               meta_we;
    logic [SW-1:0]      wslot;
    logic [NAME_AW-1:0] name_waddr;
    meta_t              meta_rd_reg;
    logic [7:0]         name_rd_reg;

    assign slot_ok    = 32'(load.slot) < MAX_FILES;
    assign name_we    = load.we && slot_ok && (load.off < LD_ATTR);
    assign meta_we    = load.we && slot_ok && (load.off >= LD_ATTR) && (load.off <= LD_SIZE_HI);
    assign wslot      = SW'(load.slot);
    assign name_waddr = NAME_AW'(32'(load.slot) * NAME_LEN + 32'(load.off));

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[name_waddr] <= load.value;
        end
        if (rd_en)
        begin
            name_rd_reg <= name_mem[name_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            case (load.off)
                LD_ATTR:    meta_mem[wslot].writable  <= |load.value;
                LD_TIME_LO: meta_mem[wslot].tm[7:0]    <= load.value;
                LD_TIME_HI: meta_mem[wslot].tm[15:8]   <= load.value;
                LD_DATE_LO: meta_mem[wslot].date[7:0]  <= load.value;
                LD_DATE_HI: meta_mem[wslot].date[15:8] <= load.value;
                LD_SIZE_LO: meta_mem[wslot].size[7:0]  <= load.value;
                LD_SIZE_HI: meta_mem[wslot].size[15:8] <= load.value;
                default:    ;
            endcase
        end
        if (rd_en)
        begin
            meta_rd_reg <= meta_mem[meta_raddr];
        end
    end

    assign meta_rd = meta_rd_reg;
    assign name_rd = name_rd_reg;

endmodule

`default_nettype wire

// ===== sv/fvd_addr_gen.sv =====
// Packet address sequencer with region decode and file table read addressing.
`default_nettype none

module fvd_addr_gen
    import fvd_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 64,
    parameter int unsigned MAX_FILES    = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] start_address,
    input  wire logic              adv,
    output logic                   ready,
    output logic                   issue,
    output s1_info_t               info,
    output logic [((MAX_FILES > 1) ? $clog2(MAX_FILES) : 1)-1:0] meta_raddr,
    output logic [$clog2(NAME_LEN * MAX_FILES)-1:0]             name_raddr
);

    localparam int unsigned CW      = $clog2(PACKET_BYTES);
    localparam int unsigned SW      = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int unsigned NAME_AW = $clog2(NAME_LEN * MAX_FILES);
    localparam logic [CW-1:0] LAST_CNT = CW'(PACKET_BYTES - 1);

    logic              active_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              last;

    logic [ADDR_W-1:0] fat1_idx;
    logic [ADDR_W-1:0] fat2_idx;
    logic [ADDR_W-1:0] root_idx;
    logic [ADDR_W-1:0] data_idx;
    logic [14:0]       fat_idx;
    logic [14:0]       fat_rel;
    logic [8:0]        root_hi;

    assign last  = (cnt_reg == LAST_CNT);
    assign issue = active_reg;
    assign ready = !active_reg || (adv && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            addr_reg   <= '0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            addr_reg   <= start_address;
            cnt_reg    <= '0;
        end
        else if (adv && active_reg)
        begin
            addr_reg <= addr_reg + 1'b1;
            cnt_reg  <= cnt_reg + 1'b1;
            if (last)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign fat1_idx = addr_reg - FAT1_BASE;
    assign fat2_idx = addr_reg - FAT2_BASE;
    assign root_idx = addr_reg - ROOT_BASE;
    assign data_idx = addr_reg - DATA_BASE;
    assign fat_idx  = (addr_reg < FAT2_BASE) ? fat1_idx[14:0] : fat2_idx[14:0];
    assign fat_rel  = fat_idx - 15'd4;
    assign root_hi  = root_idx[13:5];

    always_comb
    begin
        info      = '0;
        info.last = last;
        if (addr_reg < FAT1_BASE)
        begin
            info.region = RGN_BOOT;
            info.off    = 15'(addr_reg[8:0]);
        end
        else if (addr_reg < ROOT_BASE)
        begin
            info.region = RGN_FAT;
            info.aux    = (fat_idx < 15'd4);
            info.off    = fat_idx;
            info.fi     = {1'b0, fat_rel[14:7]};
        end
        else if (addr_reg < DATA_BASE)
        begin
            info.region = RGN_ROOT;
            info.aux    = (root_hi == 9'd0);
            info.off    = 15'(root_idx[4:0]);
            info.fi     = root_hi - 9'd1;
        end
        else
        begin
            info.region = RGN_DATA;
            info.off    = data_idx[14:0];
            info.fi     = {1'b0, data_idx[22:15]};
        end
    end

    assign meta_raddr = SW'(info.fi);
    assign name_raddr = NAME_AW'(32'(meta_raddr) * NAME_LEN + 32'(info.off[3:0]));

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && adv && last |=> !active_reg || (cnt_reg == '0))
        else $error("packet sequencer ran past its last byte");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> active_reg && (cnt_reg == '0) && (addr_reg == $past(start_address)))
        else $error("read transfer did not start the sequencer");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !adv |=> active_reg && $stable(addr_reg) && $stable(cnt_reg))
        else $error("sequencer moved while the pipeline was stalled");

endmodule

`default_nettype wire

// ===== sv/fvd_byte_build.sv =====
// Byte assembly stage and output register: boot sector, FAT chains, directory entries, file flags.
`default_nettype none

module fvd_byte_build
    import fvd_pkg::*;
#(
    parameter int unsigned MAX_FILES = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       issue,
    input  wire s1_info_t   info,
    input  wire meta_t      meta_rd,
    input  wire logic [7:0] name_rd,
    input  wire logic [4:0] file_count,
    output logic            adv,
    fvd_byte_if.source      rsp
);

    localparam logic [4:0] DIR_ATTR  = 5'd11;
    localparam logic [4:0] DIR_CTIME = 5'd14;
    localparam logic [4:0] DIR_CDATE = 5'd16;
    localparam logic [4:0] DIR_ADATE = 5'd18;
    localparam logic [4:0] DIR_MTIME = 5'd22;
    localparam logic [4:0] DIR_MDATE = 5'd24;
    localparam logic [4:0] DIR_CLUS  = 5'd26;
    localparam logic [4:0] DIR_SIZE  = 5'd28;

    logic        s1_valid_reg;
    s1_info_t    s1_reg;
    logic        out_valid_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic        flag_reg;
    logic [3:0]  slot_reg;
    logic [14:0] foff_reg;

    logic [8:0]  act;
    logic        in_use;
    logic [15:0] eff;
    logic [6:0]  used;
    logic [14:0] fat_rel;
    logic [5:0]  co;
    logic [15:0] entry;
    logic [15:0] clus;
    logic [4:0]  off5;
    logic [7:0]  data_c;
    logic        flag_c;

    assign adv = !out_valid_reg || rsp.ready;

    assign act     = (9'(file_count) > 9'(MAX_FILES)) ? 9'(MAX_FILES) : 9'(file_count);
    assign in_use  = s1_reg.fi < act;
    assign eff     = (meta_rd.size > SIZE_CAP) ? SIZE_CAP : meta_rd.size;
    assign used    = eff[15:9] + 7'(|eff[8:0]);
    assign fat_rel = s1_reg.off - 15'd4;
    assign co      = fat_rel[6:1];
    assign clus    = {1'b0, s1_reg.fi, 6'd2};
    assign off5    = s1_reg.off[4:0];

    always_comb
    begin
        entry = FAT_BAD;
        if (s1_reg.aux)
        begin
            entry = s1_reg.off[1] ? FAT_RSVD : FAT_MEDIA;
        end
        else if (in_use && ({1'b0, co} < used))
        begin
            entry = ((7'(co) + 7'd1) < used) ? (16'({s1_reg.fi[7:0], co}) + 16'd3) : FAT_EOC;
        end
    end

    always_comb
    begin
        data_c = 8'h00;
        flag_c = 1'b0;
        case (s1_reg.region)
            RGN_BOOT:
            begin
                if (s1_reg.off[8:0] < BOOT_ROM_LEN)
                    data_c = boot_rom_byte(s1_reg.off[5:0]);
                else if (s1_reg.off[8:0] == BOOT_SIG_POS)
                    data_c = BOOT_SIG_LO;
                else if (s1_reg.off[8:0] == BOOT_SIG_POS + 9'd1)
                    data_c = BOOT_SIG_HI;
                else
                    data_c = BOOT_FILL;
            end
            RGN_FAT:
            begin
                data_c = s1_reg.off[0] ? entry[15:8] : entry[7:0];
            end
            RGN_ROOT:
            begin
                if (s1_reg.aux)
                    data_c = label_rom_byte(off5);
                else if (!in_use)
                    data_c = 8'h00;
                else if (off5 < DIR_ATTR)
                    data_c = name_rd;
                else if (off5 == DIR_ATTR)
                    data_c = meta_rd.writable ? 8'h00 : ATTR_RO;
                else if (off5 == DIR_CTIME || off5 == DIR_MTIME)
                    data_c = meta_rd.tm[7:0];
                else if (off5 == DIR_CTIME + 5'd1 || off5 == DIR_MTIME + 5'd1)
                    data_c = meta_rd.tm[15:8];
                else if (off5 == DIR_CDATE || off5 == DIR_ADATE || off5 == DIR_MDATE)
                    data_c = meta_rd.date[7:0];
                else if (off5 == DIR_CDATE + 5'd1 || off5 == DIR_ADATE + 5'd1
                         || off5 == DIR_MDATE + 5'd1)
                    data_c = meta_rd.date[15:8];
                else if (off5 == DIR_CLUS)
                    data_c = clus[7:0];
                else if (off5 == DIR_CLUS + 5'd1)
                    data_c = clus[15:8];
                else if (off5 == DIR_SIZE)
                    data_c = eff[7:0];
                else if (off5 == DIR_SIZE + 5'd1)
                    data_c = eff[15:8];
                else
                    data_c = 8'h00;
            end
            RGN_DATA:
            begin
                flag_c = in_use && ({1'b0, s1_reg.off} < eff);
            end
            default:
            begin
                data_c = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= info;
            data_reg <= data_c;
            last_reg <= s1_reg.last;
            flag_reg <= flag_c;
            slot_reg <= flag_c ? s1_reg.fi[3:0] : 4'd0;
            foff_reg <= flag_c ? s1_reg.off : 15'd0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.data_byte      = data_reg;
    assign rsp.last_byte      = last_reg;
    assign rsp.file_byte_flag = flag_reg;
    assign rsp.file_slot      = slot_reg;
    assign rsp.file_offset    = foff_reg;

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.file_byte_flag |-> rsp.data_byte == 8'h00)
        else $error("flagged file byte carries nonzero data");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_reg))
        else $error("stalled byte dropped from the assembly stage");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && adv |=> rsp.valid)
        else $error("assembled byte lost before the output register");

endmodule

`default_nettype wire

// ===== sv/fat16_virtual_disk_reader_top.sv =====
// Top level of the FAT16 virtual disk image reader.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------------
//  req     | in  | valid/ready  | req_type, start_address, load_slot/offset/value
//  rsp     | out | valid/ready  | data_byte, last_byte, file_byte_flag, slot, offset
//  cfg     | in  | cfg_we       | cfg_wdata = file_count
//
// A read transfer produces PACKET_BYTES bytes, one per cycle while rsp does not stall; the
// next request is taken on the cycle the last byte issues, so packets stream back to back.
// A load is taken while the sequencer is idle or on its last byte. Bytes pass the assembly
// register and then the output register. rsp stalls freeze the whole pipeline in place.
// Reset clears control only; the file table needs no clearing pass.
`default_nettype none

module fat16_virtual_disk_reader_top
    import fvd_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 64,
    parameter int unsigned MAX_FILES    = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    fvd_req_if.sink         req,
    fvd_byte_if.source      rsp,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata
);

    localparam int unsigned SW      = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int unsigned NAME_AW = $clog2(NAME_LEN * MAX_FILES);

    logic [4:0]         file_count_reg;
    logic               req_ready;
    logic               accept;
    logic               start;
    logic               adv;
    logic               issue;
    s1_info_t           info;
    load_t              load;
    logic [SW-1:0]      meta_raddr;
    logic [NAME_AW-1:0] name_raddr;
    meta_t              meta_rd;
    logic [7:0]         name_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_count_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            file_count_reg <= cfg_wdata;
        end
    end

    assign req.ready  = req_ready;
    assign accept     = req.valid && req_ready;
    assign start      = accept && (req.req_type == REQ_READ);
    assign load.we    = accept && (req.req_type == REQ_LOAD);
    assign load.slot  = req.load_slot;
    assign load.off   = req.load_byte_offset;
    assign load.value = req.load_value;

    fvd_addr_gen #(
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_FILES    (MAX_FILES)
    ) u_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .start_address (req.start_address),
        .adv           (adv),
        .ready         (req_ready),
        .issue         (issue),
        .info          (info),
        .meta_raddr    (meta_raddr),
        .name_raddr    (name_raddr)
    );

    fvd_file_table #(
        .MAX_FILES (MAX_FILES)
    ) u_table (
        .clk        (clk),
        .load       (load),
        .rd_en      (adv),
        .meta_raddr (meta_raddr),
        .name_raddr (name_raddr),
        .meta_rd    (meta_rd),
        .name_rd    (name_rd)
    );

    fvd_byte_build #(
        .MAX_FILES (MAX_FILES)
    ) u_build (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .info       (info),
        .meta_rd    (meta_rd),
        .name_rd    (name_rd),
        .file_count (file_count_reg),
        .adv        (adv),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the FAT16 image reader: byte predictor, scoreboard, stimulus and response checks.
`timescale 1ns / 1ps

package disk_check_pkg;
    import fvd_pkg::*;

    localparam int unsigned PKT_LEN    = 64;
    localparam int unsigned SLOTS      = 16;
    localparam int unsigned BOOT_SPAN  = 512;
    localparam int unsigned IMG_FAT1   = 512;
    localparam int unsigned IMG_FAT2   = 512 * 65;
    localparam int unsigned IMG_ROOT   = 512 * 129;
    localparam int unsigned IMG_DATA   = 512 * 161;
    localparam int unsigned FILE_SPAN  = 32768;
    localparam int unsigned SIZE_LIMIT = 32768;
    localparam int unsigned CLUSTER    = 512;
    localparam int unsigned DIR_ENTRY  = 32;
    localparam int unsigned SHOW_MAX   = 20;

    localparam logic [7:0]  SIG_FIRST  = 8'h55;
    localparam logic [7:0]  SIG_SECOND = 8'hAA;
    localparam logic [7:0]  PAD_BYTE   = 8'h90;
    localparam logic [7:0]  RO_ATTR    = 8'h01;
    localparam logic [15:0] MEDIA_HIGH = 16'hFF00;
    localparam logic [15:0] RSVD_ENTRY = 16'hFFFF;
    localparam logic [15:0] CHAIN_END  = 16'hFFF8;
    localparam logic [15:0] NO_CLUSTER = 16'hFFF7;

    localparam logic [7:0] BOOT_TBL [62] = '{
        8'hEB, 8'h3E, 8'h90, 8'h4D, 8'h53, 8'h44, 8'h4F, 8'h53, 8'h35, 8'h2E, 8'h30,
        8'h00, 8'h02, 8'h01, 8'h01, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00,
        8'hF8, 8'h40, 8'h00, 8'h20, 8'h00, 8'h01, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
        8'h80, 8'h00, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h43, 8'h48, 8'h35, 8'h35, 8'h58, 8'h20, 8'h4D, 8'h53, 8'h44, 8'h20, 8'h20,
        8'h46, 8'h41, 8'h54, 8'h31, 8'h36, 8'h20, 8'h20, 8'h20
    };

    localparam logic [7:0] LABEL_TBL [32] = '{
        8'h43, 8'h48, 8'h35, 8'h35, 8'h58, 8'h20, 8'h4D, 8'h53, 8'h44, 8'h20, 8'h20,
        8'h08, 8'h00, 8'h00, 8'h5C, 8'h64, 8'h22, 8'h52, 8'h22, 8'h52, 8'h00, 8'h00,
        8'h5C, 8'h64, 8'h22, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic        req_type;
        logic [22:0] addr;
        logic [3:0]  slot;
        logic [4:0]  boff;
        logic [7:0]  value;
    } disk_req_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        flag;
        logic [3:0]  slot;
        logic [14:0] offset;
    } disk_byte_t;

    typedef struct packed {
        logic [22:0] addr;
        disk_byte_t  b;
    } byte_expect_t;

    class image_scoreboard;
        logic [7:0]   names [SLOTS][11];
        logic         writable [SLOTS];
        logic [15:0]  times [SLOTS];
        logic [15:0]  dates [SLOTS];
        logic [15:0]  sizes [SLOTS];
        logic [4:0]   file_count;
        byte_expect_t pending [$];
        int unsigned  errors;

        function new();
            file_count = '0;
            errors = 0;
        endfunction

        function int unsigned files_in_use();
            return (file_count > SLOTS) ? SLOTS : int'(file_count);
        endfunction

        function int unsigned eff_size(int unsigned f);
            int unsigned s;
            s = sizes[f];
            return (s > SIZE_LIMIT) ? SIZE_LIMIT : s;
        endfunction

        function void store_load(logic [3:0] s, logic [4:0] o, logic [7:0] v);
            if (o < LD_ATTR)
                names[s][o] = v;
            else if (o == LD_ATTR)
                writable[s] = (v != 8'h00);
            else if (o == LD_TIME_LO)
                times[s][7:0] = v;
            else if (o == LD_TIME_HI)
                times[s][15:8] = v;
            else if (o == LD_DATE_LO)
                dates[s][7:0] = v;
            else if (o == LD_DATE_HI)
                dates[s][15:8] = v;
            else if (o == LD_SIZE_LO)
                sizes[s][7:0] = v;
            else if (o == LD_SIZE_HI)
                sizes[s][15:8] = v;
        endfunction

        function logic [7:0] fat_byte(int unsigned idx);
            logic [15:0] entry;
            int unsigned rel, f, c, used;
            entry = NO_CLUSTER;
            if (idx < 2)
                entry = MEDIA_HIGH | {8'h00, BOOT_TBL[21]};
            else if (idx < 4)
                entry = RSVD_ENTRY;
            else
            begin
                rel = (idx - 4) / 2;
                f = rel / 64;
                c = rel % 64;
                if (f < files_in_use())
                begin
                    used = (eff_size(f) + CLUSTER - 1) / CLUSTER;
                    if (c < used)
                        entry = (c + 1 < used) ? 16'(64 * f + c + 3) : CHAIN_END;
                end
            end
            return idx[0] ? entry[15:8] : entry[7:0];
        endfunction

        function logic [7:0] dir_byte(int unsigned idx);
            int unsigned f, o;
            logic [15:0] w;
            if (idx < DIR_ENTRY)
                return LABEL_TBL[idx];
            if (idx >= DIR_ENTRY * (1 + files_in_use()))
                return 8'h00;
            f = idx / DIR_ENTRY - 1;
            o = idx % DIR_ENTRY;
            if (o < 11)
                return names[f][o];
            if (o == 11)
                return writable[f] ? 8'h00 : RO_ATTR;
            case (o)
                14, 15, 22, 23:         w = times[f];
                16, 17, 18, 19, 24, 25: w = dates[f];
                26, 27:                 w = 16'(2 + 64 * f);
                28, 29:                 w = 16'(eff_size(f));
                default:                w = 16'h0000;
            endcase
            return o[0] ? w[15:8] : w[7:0];
        endfunction

        function disk_byte_t image_byte(logic [22:0] a, bit last);
            disk_byte_t b;
            int unsigned d, f, o;
            b = '0;
            b.last = last;
            if (a < BOOT_SPAN)
            begin
                if (a < 62)
                    b.data = BOOT_TBL[a];
                else if (a == BOOT_SPAN - 2)
                    b.data = SIG_FIRST;
                else if (a == BOOT_SPAN - 1)
                    b.data = SIG_SECOND;
                else
                    b.data = PAD_BYTE;
            end
            else if (a < IMG_FAT2)
                b.data = fat_byte(a - IMG_FAT1);
            else if (a < IMG_ROOT)
                b.data = fat_byte(a - IMG_FAT2);
            else if (a < IMG_DATA)
                b.data = dir_byte(a - IMG_ROOT);
            else
            begin
                d = a - IMG_DATA;
                f = d / FILE_SPAN;
                o = d % FILE_SPAN;
                if (f < files_in_use() && o < eff_size(f))
                begin
                    b.flag = 1'b1;
                    b.slot = f[3:0];
                    b.offset = o[14:0];
                end
            end
            return b;
        endfunction

        function void note_transfer(disk_req_t r);
            logic [22:0] a;
            if (r.req_type == REQ_LOAD)
            begin
                store_load(r.slot, r.boff, r.value);
                return;
            end
            for (int unsigned i = 0; i < PKT_LEN; i++)
            begin
                a = r.addr + 23'(i);
                pending.push_back('{addr: a, b: image_byte(a, i == PKT_LEN - 1)});
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= SHOW_MAX)
                $display("mismatch: %s", msg);
        endtask

        task check_transfer(disk_byte_t got);
            byte_expect_t x;
            if (pending.size() == 0)
            begin
                report($sformatf("byte %02h with nothing outstanding", got.data));
                return;
            end
            x = pending.pop_front();
            if (got.data !== x.b.data)
                report($sformatf("addr %06h data_byte %02h, want %02h",
                                 x.addr, got.data, x.b.data));
            if (got.last !== x.b.last)
                report($sformatf("addr %06h last_byte %0b, want %0b",
                                 x.addr, got.last, x.b.last));
            if (got.flag !== x.b.flag)
                report($sformatf("addr %06h file_byte_flag %0b, want %0b",
                                 x.addr, got.flag, x.b.flag));
            if (got.slot !== x.b.slot)
                report($sformatf("addr %06h file_slot %0d, want %0d",
                                 x.addr, got.slot, x.b.slot));
            if (got.offset !== x.b.offset)
                report($sformatf("addr %06h file_offset %0d, want %0d",
                                 x.addr, got.offset, x.b.offset));
        endtask
    endclass

endpackage

module tb;
    import fvd_pkg::*;
    import disk_check_pkg::*;

    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS   = 30;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [4:0]      cfg_wdata;
    bit              hold_now = 1'b0;
    bit              offering = 1'b0;
    int unsigned     burst_left = 0;
    int unsigned     idle_cycles = 0;
    image_scoreboard sb;

    fvd_req_if  req_ch ();
    fvd_byte_if byte_ch ();

    fat16_virtual_disk_reader_top #(
        .PACKET_BYTES(PKT_LEN),
        .MAX_FILES(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(byte_ch),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin : watch
        disk_req_t  rq;
        disk_byte_t rb;
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if (cfg_we)
                sb.file_count = cfg_wdata;
            if (req_ch.valid && req_ch.ready)
            begin
                rq.req_type = req_ch.req_type;
                rq.addr = req_ch.start_address;
                rq.slot = req_ch.load_slot;
                rq.boff = req_ch.load_byte_offset;
                rq.value = req_ch.load_value;
                sb.note_transfer(rq);
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                rb.data = byte_ch.data_byte;
                rb.last = byte_ch.last_byte;
                rb.flag = byte_ch.file_byte_flag;
                rb.slot = byte_ch.file_slot;
                rb.offset = byte_ch.file_offset;
                sb.check_transfer(rb);
            end
            if (cfg_we || (req_ch.valid && req_ch.ready) || (byte_ch.valid && byte_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int unsigned mode;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 150))
            begin
                if (hold_now)
                begin
                    byte_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_now = 1'b0;
                end
                case (mode)
                    0:       byte_ch.ready <= 1'b1;
                    1:       byte_ch.ready <= 1'($urandom_range(0, 1));
                    default: byte_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task send_request(disk_req_t r);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.start_address <= r.addr;
        req_ch.load_slot <= r.slot;
        req_ch.load_byte_offset <= r.boff;
        req_ch.load_value <= r.value;
        offering = 1'b1;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    task load_byte(logic [3:0] s, logic [4:0] o, logic [7:0] v);
        disk_req_t r;
        r.req_type = REQ_LOAD;
        r.addr = 23'($urandom);
        r.slot = s;
        r.boff = o;
        r.value = v;
        send_request(r);
    endtask

    task read_packet(logic [22:0] a);
        disk_req_t r;
        r.req_type = REQ_READ;
        r.addr = a;
        r.slot = 4'($urandom);
        r.boff = 5'($urandom);
        r.value = 8'($urandom);
        send_request(r);
    endtask

    task load_record(logic [3:0] s, logic [15:0] size);
        for (int k = 0; k < 11; k++)
            load_byte(s, 5'(k), 8'($urandom));
        load_byte(s, LD_ATTR, ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(1, 255)));
        load_byte(s, LD_TIME_LO, 8'($urandom));
        load_byte(s, LD_TIME_HI, 8'($urandom));
        load_byte(s, LD_DATE_LO, 8'($urandom));
        load_byte(s, LD_DATE_HI, 8'($urandom));
        load_byte(s, LD_SIZE_LO, size[7:0]);
        load_byte(s, LD_SIZE_HI, size[15:8]);
    endtask

    task drain();
        if (offering)
        begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task configure(logic [4:0] count);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [22:0] pick_address();
        int unsigned f, o, es, used, base;
        logic [22:0] a;
        f = $urandom_range(0, SLOTS + 1);
        es = sb.eff_size(f % SLOTS);
        used = (es + CLUSTER - 1) / CLUSTER;
        case ($urandom_range(0, 9))
            0:
                a = 23'($urandom_range(0, BOOT_SPAN - 1));
            1, 2:
            begin
                base = ($urandom_range(0, 1) == 1) ? IMG_FAT1 : IMG_FAT2;
                o = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 63) : used;
                a = 23'(base + 4 + 2 * (64 * f + o) - $urandom_range(0, 40));
            end
            3:
                a = 23'(IMG_FAT1 + $urandom_range(0, IMG_ROOT - IMG_FAT1 - 1));
            4, 5:
                a = 23'(IMG_ROOT + $urandom_range(0, DIR_ENTRY * (SLOTS + 2)));
            6:
                a = 23'(IMG_ROOT + $urandom_range(0, IMG_DATA - IMG_ROOT - 1));
            7, 8:
            begin
                if ($urandom_range(0, 1) == 1)
                    o = $urandom_range(0, FILE_SPAN - 1);
                else
                    o = (es + FILE_SPAN - $urandom_range(0, 63)) % FILE_SPAN;
                a = 23'(IMG_DATA + f * FILE_SPAN + o);
            end
            default:
                a = ($urandom_range(0, 1) == 1) ? 23'($urandom)
                                                 : 23'h7FFFFF - 23'($urandom_range(0, 127));
        endcase
        if ($urandom_range(0, 4) != 0)
            a[5:0] = '0;
        return a;
    endfunction

    task random_phase(logic [4:0] count, bit squeeze);
        configure(count);
        if (squeeze)
            hold_now = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                load_byte(4'($urandom),
                          ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31))
                                                       : 5'($urandom_range(0, 17)),
                          ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
            else
                read_packet(pick_address());
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] fill_sizes [SLOTS];
        logic [4:0]  counts [7];
        sb = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_LOAD;
        req_ch.start_address <= '0;
        req_ch.load_slot <= '0;
        req_ch.load_byte_offset <= '0;
        req_ch.load_value <= '0;
        fill_sizes = '{16'd1, 16'd0, 16'd511, 16'd512, 16'd513, 16'd1000, 16'd4096, 16'd32767,
                       16'd32768, 16'd32769, 16'hFFFF, 16'd64, 16'd200, 16'($urandom),
                       16'($urandom), 16'd1536};
        counts = '{5'd16, 5'd31, 5'd1, 5'd17, 5'($urandom_range(2, 15)), 5'd0, 5'd16};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: fixed regions only
        configure(5'd0);
        read_packet(23'd0);
        read_packet(23'd30);
        read_packet(23'(BOOT_SPAN - PKT_LEN));
        read_packet(23'(IMG_FAT1));
        read_packet(23'(IMG_FAT2 - 32));
        read_packet(23'(IMG_ROOT));
        read_packet(23'(IMG_DATA - 32));
        read_packet(23'h7FFFC0);
        read_packet(23'h7FFFFF);
        load_byte(4'd15, 5'd18, 8'hFF);
        load_byte(4'd0, 5'd31, 8'h00);

        for (int s = 0; s < SLOTS; s++)
            load_record(4'(s), fill_sizes[s]);

        configure(5'd16);
        read_packet(23'(IMG_ROOT + DIR_ENTRY));
        read_packet(23'(IMG_ROOT + DIR_ENTRY * SLOTS));
        read_packet(23'(IMG_FAT1));
        read_packet(23'(IMG_FAT2 + 4 + 2 * 64 * 3));
        read_packet(23'(IMG_DATA + 3 * FILE_SPAN + 512 - 32));
        read_packet(23'(IMG_DATA + 9 * FILE_SPAN + FILE_SPAN - 32));
        read_packet(23'(IMG_DATA + 15 * FILE_SPAN + FILE_SPAN - 32));

        for (int p = 0; p < 7; p++)
            random_phase(counts[p], p == 1);

        drain();
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fvd_pkg.sv
sv/fvd_ifs.sv
sv/fvd_file_table.sv
sv/fvd_addr_gen.sv
sv/fvd_byte_build.sv
sv/fat16_virtual_disk_reader_top.sv
tb/tb.sv
